/* hw/rtl/grid_dispersal_step_defines.svh */
// Assertion macros shared by the checker of grid_dispersal_step.
// Depends on nothing; included by name from the checker file.
`ifndef GRID_DISPERSAL_STEP_DEFINES_SVH
`define GRID_DISPERSAL_STEP_DEFINES_SVH

// Overlapping implication, switched off while reset is high.
`define GDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid_dispersal_step assertion failed");

// Next-cycle implication that stays active through reset.
`define GDS_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("grid_dispersal_step assertion failed");

`endif

/* hw/rtl/gds_pkg.sv */
// Package of the grid dispersal step: constants, codes, payload and pipeline types.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package gds_pkg;

   localparam int MAX_DIMS   = 4;
   localparam int MAX_LENGTH = 1024;
   localparam int MAX_JUMP   = 1023;
   localparam int COORD_W    = 10;
   localparam int LEN_W      = 11;
   localparam int DIMS_W     = 3;
   localparam int DRAW_W     = 16;
   localparam int PATCH_W    = 40;
   localparam int POS_W      = 12;
   localparam int LATENCY    = 10;

   typedef enum logic [1:0] {
      DISP_GLOBAL   = 2'd0,
      DISP_NEIGHBOR = 2'd1,
      DISP_DISTANCE = 2'd2
   } disp_mode_type;

   typedef enum logic [1:0] {
      BOUND_REFLECT  = 2'd0,
      BOUND_CIRCULAR = 2'd1,
      BOUND_ABSORB   = 2'd2
   } bound_mode_type;

   typedef enum logic [1:0] {
      CSR_GRID_LENGTH     = 2'd0,
      CSR_DIMENSION_COUNT = 2'd1,
      CSR_DISPERSAL_MODE  = 2'd2,
      CSR_BOUNDARY_MODE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] coord_0;
      logic [COORD_W-1:0] coord_1;
      logic [COORD_W-1:0] coord_2;
      logic [COORD_W-1:0] coord_3;
      logic [15:0]        disperse_draw;
      logic [16:0]        disperse_prob;
      logic [15:0]        direction_draw;
      logic [COORD_W-1:0] jump_distance;
      logic [15:0]        global_draw_0;
      logic [15:0]        global_draw_1;
      logic [15:0]        global_draw_2;
      logic [15:0]        global_draw_3;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] new_coord_0;
      logic [COORD_W-1:0] new_coord_1;
      logic [COORD_W-1:0] new_coord_2;
      logic [COORD_W-1:0] new_coord_3;
      logic [PATCH_W-1:0] linear_patch;
      logic               moved;
      logic               killed;
   } rsp_type;

   typedef logic [MAX_DIMS-1:0][COORD_W-1:0] coords_type;

   typedef struct packed {
      coords_type         cur;
      coords_type         gq;
      logic               moved;
      logic               global_sel;
      logic [COORD_W-1:0] step;
      logic [18:0]        t;
   } s1_type;

   typedef struct packed {
      coords_type         coord;
      logic [COORD_W-1:0] cur_c;
      logic [POS_W-1:0]   p;
      logic               inrange;
      logic               neg;
      logic               jump;
      logic               moved;
      logic [1:0]         dim;
      logic [LEN_W-1:0]   mag;
      logic [LEN_W-1:0]   modulus;
   } mid_type;

   typedef struct packed {
      coords_type         coord;
      logic               moved;
      logic               killed;
      logic [PATCH_W-1:0] lin;
   } out_type;

endpackage

/* hw/rtl/gds_rem.sv */
// Pipelined remainder unit, four stages of three restoring steps each.
// Depends on gds_pkg for the operand widths.
`timescale 1ns / 1ps

module gds_rem import gds_pkg::*; (
   input  logic             clock,
   input  logic [LEN_W-1:0] dividend,
   input  logic [LEN_W-1:0] modulus,
   output logic [LEN_W-1:0] rem
);

   localparam int STAGES = 4;
   localparam int STEPS  = 3;
   localparam int WIDE_W = 2 * LEN_W + 1;

   logic [LEN_W-1:0] rem_ff [STAGES];
   logic [LEN_W-1:0] mod_ff [STAGES];
   logic [LEN_W-1:0] rem_in [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int TOP = STAGES * STEPS - 1 - STEPS * s;
      logic [LEN_W-1:0] r_src;
      logic [LEN_W-1:0] m_src;

      assign r_src = (s == 0) ? dividend : rem_ff[(s == 0) ? 0 : s - 1];
      assign m_src = (s == 0) ? modulus  : mod_ff[(s == 0) ? 0 : s - 1];

      always_comb begin
         logic [WIDE_W-1:0] r;
         logic [WIDE_W-1:0] sub;
         r = WIDE_W'(r_src);
         for (int k = 0; k < STEPS; k++) begin
            sub = WIDE_W'(m_src) << (TOP - k);
            if (r >= sub) begin
               r = r - sub;
            end
         end
         rem_in[s] = r[LEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in[s];
         mod_ff[s] <= m_src;
      end
   end

   assign rem = rem_ff[STAGES-1];

endmodule

/* hw/rtl/grid_dispersal_step.sv */
// Top level of the grid dispersal step: configuration registers and the move pipeline.
// Depends on gds_pkg and the remainder unit gds_rem.
//
// Usage. A request carries one individual's coordinates and its pre-drawn random
// values. It is accepted at a rising edge with start high and busy low; busy is
// high only while reset is high, so a new request may be issued in every cycle.
// Each request yields exactly one result, shown on rsp_payload for one cycle with
// rsp_valid high. Throughput is one request per cycle; the ten pipeline registers are
// input products, step and bounds, four stages of the boundary remainder unit,
// boundary fix-up and three Horner stages of the linear patch index.
// The result cannot be held off by the receiver, so the pipeline never stalls.
// The APB-style port holds grid_length, dimension_count, dispersal_mode and
// boundary_mode at byte addresses 0, 4, 8 and 12, always ready; write them only
// while no request is in flight. Synchronous reset restores the register defaults
// and drops every request still in the pipeline.
`timescale 1ns / 1ps

module grid_dispersal_step import gds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_valid,
   output rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Configuration registers.
   logic [LEN_W-1:0]  len_ff;
   logic [DIMS_W-1:0] dims_ff;
   logic [1:0]        disp_ff;
   logic [1:0]        bound_ff;
   csr_index_type     csr_idx;

   assign pready  = 1'b1;
   assign busy    = reset;
   assign csr_idx = csr_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= LEN_W'(16);
         dims_ff  <= DIMS_W'(1);
         disp_ff  <= DISP_NEIGHBOR;
         bound_ff <= BOUND_REFLECT;
      end else if (psel && penable && pwrite) begin
         case (csr_idx)
            CSR_GRID_LENGTH:     len_ff   <= pwdata[LEN_W-1:0];
            CSR_DIMENSION_COUNT: dims_ff  <= pwdata[DIMS_W-1:0];
            CSR_DISPERSAL_MODE:  disp_ff  <= pwdata[1:0];
            CSR_BOUNDARY_MODE:   bound_ff <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_GRID_LENGTH:     prdata = 32'(len_ff);
         CSR_DIMENSION_COUNT: prdata = 32'(dims_ff);
         CSR_DISPERSAL_MODE:  prdata = 32'(disp_ff);
         CSR_BOUNDARY_MODE:   prdata = 32'(bound_ff);
         default:             prdata = 32'd0;
      endcase
   end

   // Effective settings: the length saturates at the largest grid, and the
   // dimension count is held between one and the largest dimension count.
   logic [LEN_W-1:0]  glen;
   logic [DIMS_W-1:0] dims;
   logic              circ;
   logic              absorb;

   assign glen   = (len_ff > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : len_ff;
   assign dims   = (dims_ff == '0) ? DIMS_W'(1) :
                   (dims_ff > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : dims_ff;
   assign circ   = (bound_ff == BOUND_CIRCULAR);
   assign absorb = (bound_ff == BOUND_ABSORB);

   // Valid bits that travel with the request through all ten stages.
   logic [LATENCY-1:0] vld_ff;
   logic               accept;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LATENCY-2:0], accept};
      end
   end

   // Stage 1: the dispersal test, the direction product and the global redraws.
   s1_type s1_in;
   s1_type s1_ff;

   always_comb begin
      logic [15:0] gdraw [MAX_DIMS];
      gdraw[0] = req_payload.global_draw_0;
      gdraw[1] = req_payload.global_draw_1;
      gdraw[2] = req_payload.global_draw_2;
      gdraw[3] = req_payload.global_draw_3;
      s1_in.cur[0]    = req_payload.coord_0;
      s1_in.cur[1]    = req_payload.coord_1;
      s1_in.cur[2]    = req_payload.coord_2;
      s1_in.cur[3]    = req_payload.coord_3;
      s1_in.moved     = (glen > LEN_W'(1)) && (disp_ff <= DISP_DISTANCE) &&
                        ({1'b0, req_payload.disperse_draw} < req_payload.disperse_prob);
      s1_in.global_sel = (disp_ff == DISP_GLOBAL);
      s1_in.t         = 19'(req_payload.direction_draw) * 19'(dims);
      if (disp_ff != DISP_DISTANCE) begin
         s1_in.step = COORD_W'(1);
      end else if (req_payload.jump_distance == '0) begin
         s1_in.step = COORD_W'(1);
      end else if (req_payload.jump_distance > COORD_W'(MAX_JUMP)) begin
         s1_in.step = COORD_W'(MAX_JUMP);
      end else begin
         s1_in.step = req_payload.jump_distance;
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         s1_in.gq[d] = COORD_W'((27'(gdraw[d]) * 27'(glen - LEN_W'(1))) >> DRAW_W);
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   // Stage 2: the trial position of a step or jump, its range test and the
   // operands of the boundary remainder.
   mid_type mid_in;
   mid_type mid_ff [5];

   always_comb begin
      logic [1:0]       dim;
      logic [POS_W-1:0] p;
      dim = s1_ff.t[17:16];
      if ({1'b0, dim} >= dims) begin
         dim = 2'(dims - DIMS_W'(1));
      end
      if (!s1_ff.t[15]) begin
         p = POS_W'(s1_ff.cur[dim]) + POS_W'(s1_ff.step);
      end else begin
         p = POS_W'(s1_ff.cur[dim]) - POS_W'(s1_ff.step);
      end
      mid_in.dim     = dim;
      mid_in.p       = p;
      mid_in.cur_c   = s1_ff.cur[dim];
      mid_in.neg     = p[POS_W-1];
      mid_in.inrange = !p[POS_W-1] && (p[LEN_W-1:0] < glen);
      mid_in.mag     = p[POS_W-1] ? LEN_W'(-p) : p[LEN_W-1:0];
      mid_in.modulus = (circ || absorb) ? glen : LEN_W'((glen - LEN_W'(1)) << 1);
      mid_in.moved   = s1_ff.moved;
      mid_in.jump    = s1_ff.moved && !s1_ff.global_sel;
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (s1_ff.moved && s1_ff.global_sel && (DIMS_W'(d) < dims)) begin
            mid_in.coord[d] = s1_ff.gq[d];
         end else begin
            mid_in.coord[d] = s1_ff.cur[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      mid_ff[0] <= mid_in;
      for (int i = 1; i < 5; i++) begin
         mid_ff[i] <= mid_ff[i-1];
      end
   end

   // Stages 3 to 6: remainder of the distance from the origin by the wrap
   // length or by the reflection period.
   logic [LEN_W-1:0] rem;

   gds_rem u_rem (
      .clock    (clock),
      .dividend (mid_ff[0].mag),
      .modulus  (mid_ff[0].modulus),
      .rem      (rem)
   );

   // Stage 7: the remainder becomes the wrapped or folded position. An absorbed
   // individual keeps its coordinates and is flagged; unused dimensions read zero.
   out_type fix_in;
   out_type fix_ff;

   always_comb begin
      mid_type          m;
      logic [LEN_W-1:0] r;
      logic [COORD_W-1:0] pos;
      logic             killed;
      m = mid_ff[4];
      r = rem;
      if (m.neg && (r != '0)) begin
         r = m.modulus - r;
      end
      if (!circ && (r >= glen)) begin
         r = m.modulus - r;
      end
      pos    = m.inrange ? m.p[COORD_W-1:0] : r[COORD_W-1:0];
      killed = m.jump && !m.inrange && absorb;
      fix_in.coord = m.coord;
      if (m.jump && !killed) begin
         fix_in.coord[m.dim] = pos;
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (DIMS_W'(d) >= dims) begin
            fix_in.coord[d] = '0;
         end
      end
      fix_in.moved  = m.moved;
      fix_in.killed = killed;
      fix_in.lin    = PATCH_W'(fix_in.coord[0]);
   end

   always_ff @(posedge clock) begin
      fix_ff <= fix_in;
   end

   // Stages 8 to 10: Horner evaluation of the row-major index, one multiply
   // per stage, first dimension most significant.
   out_type hor_in [3];
   out_type hor_ff [3];

   for (genvar h = 0; h < 3; h++) begin : g_horner
      // The partial index entering stage h is below 2**(10*(h+1)+1), so only
      // that many of its bits take part in the multiply by the grid length.
      localparam int LW = COORD_W * (h + 1) + 1;
      localparam int PW = LW + LEN_W;
      out_type         src;
      logic [PW-1:0]   prod;
      assign src  = (h == 0) ? fix_ff : hor_ff[(h == 0) ? 0 : h - 1];
      assign prod = PW'(src.lin[LW-1:0]) * PW'(glen);

      always_comb begin
         hor_in[h] = src;
         if (dims > DIMS_W'(h + 1)) begin
            hor_in[h].lin = PATCH_W'(prod) + PATCH_W'(src.coord[h + 1]);
         end
      end

      always_ff @(posedge clock) begin
         hor_ff[h] <= hor_in[h];
      end
   end

   assign rsp_valid                = vld_ff[LATENCY-1];
   assign rsp_payload.new_coord_0  = hor_ff[2].coord[0];
   assign rsp_payload.new_coord_1  = hor_ff[2].coord[1];
   assign rsp_payload.new_coord_2  = hor_ff[2].coord[2];
   assign rsp_payload.new_coord_3  = hor_ff[2].coord[3];
   assign rsp_payload.linear_patch = hor_ff[2].lin;
   assign rsp_payload.moved        = hor_ff[2].moved;
   assign rsp_payload.killed       = hor_ff[2].killed;

endmodule

/* hw/rtl/gds_checker.sv */
// Port-level checker of the grid dispersal step and its bind to the top level.
// Depends on gds_pkg and the assertion macros in grid_dispersal_step_defines.svh.
`timescale 1ns / 1ps
`include "grid_dispersal_step_defines.svh"

module gds_checker import gds_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_payload
);

   // Every accepted request yields its result after the fixed latency.
   `GDS_ASSERT_IMP(a_latency, clock, reset, start && !busy, ##10 rsp_valid)

   // No result appears without a request accepted before it.
   `GDS_ASSERT_IMP(a_no_orphan, clock, reset, rsp_valid, $past(start && !busy, 10))

   // Only a mover can be absorbed.
   `GDS_ASSERT_IMP(a_kill_moved, clock, reset, rsp_valid && rsp_payload.killed,
      rsp_payload.moved)

   // Reset drops every request in flight.
   `GDS_ASSERT_NEXT(a_reset_flush, clock, reset, !rsp_valid)

endmodule

bind grid_dispersal_step gds_checker u_gds_checker (.*);

/* verif/tb_grid_dispersal_step.sv */
// Self-checking testbench of grid_dispersal_step: directed and random dispersal requests.
// Depends on gds_pkg and the grid_dispersal_step RTL, including its remainder unit gds_rem.
`timescale 1ns / 1ps

module tb_grid_dispersal_step;
   import gds_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_payload;
   logic        rsp_valid;
   rsp_type     rsp_payload;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   grid_dispersal_step uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // The clock runs with a 20 ns period.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // The predictor keeps its own copy of the four configuration registers.
   logic [10:0] cfg_length;
   logic [2:0]  cfg_dims;
   logic [1:0]  cfg_disp;
   logic [1:0]  cfg_bound;

   rsp_type     moves_pending[$];
   int          mismatch_count = 0;
   int          result_count = 0;
   int          request_count;
   int unsigned cycle_count = 0;
   int          idle_pct;

   localparam int unsigned CYCLE_LIMIT = 400000;

   // The time limit guards against a block that stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Folds, wraps or flags a position that has left the grid.
   function automatic longint fix_position(longint p, longint len, logic [1:0] rule,
                                           output bit dead);
      longint r;
      longint period;
      dead = 1'b0;
      if (p >= 0 && p < len) return p;
      if (rule == BOUND_ABSORB) begin
         dead = 1'b1;
         return p;
      end
      if (rule == BOUND_CIRCULAR) begin
         r = p % len;
         if (r < 0) r += len;
         return r;
      end
      // Reflective and any undefined rule fold over a period of 2*(len-1).
      period = 2 * (len - 1);
      r = p % period;
      if (r < 0) r += period;
      if (r >= len) r = period - r;
      return r;
   endfunction

   // Works out where one individual ends up under the current configuration.
   function automatic rsp_type predict_move(req_type rq);
      rsp_type     res;
      longint      len;
      int          dims;
      longint      cur[4];
      longint      nxt[4];
      logic [15:0] gdraw[4];
      longint      t;
      int          dim;
      bit          plus;
      bit          dead;
      longint      step;
      logic [63:0] lin;
      len = (cfg_length > MAX_LENGTH) ? MAX_LENGTH : longint'(cfg_length);
      dims = (cfg_dims < 1) ? 1 : ((cfg_dims > MAX_DIMS) ? MAX_DIMS : int'(cfg_dims));
      cur[0] = longint'(rq.coord_0); cur[1] = longint'(rq.coord_1);
      cur[2] = longint'(rq.coord_2); cur[3] = longint'(rq.coord_3);
      gdraw[0] = rq.global_draw_0; gdraw[1] = rq.global_draw_1;
      gdraw[2] = rq.global_draw_2; gdraw[3] = rq.global_draw_3;
      for (int d = 0; d < 4; d++) nxt[d] = cur[d];
      res = '0;
      dead = 1'b0;
      if (len > 1 && cfg_disp <= DISP_DISTANCE && rq.disperse_draw < rq.disperse_prob) begin
         res.moved = 1'b1;
         if (cfg_disp == DISP_GLOBAL) begin
            for (int d = 0; d < dims; d++)
               nxt[d] = (longint'(gdraw[d]) * (len - 1)) >>> 16;
         end else begin
            t = longint'(rq.direction_draw) * dims;
            dim = int'(t >>> 16);
            plus = (t & 64'hFFFF) < 64'h8000;
            step = 1;
            if (cfg_disp == DISP_DISTANCE) begin
               step = longint'(rq.jump_distance);
               if (step < 1) step = 1;
               if (step > MAX_JUMP) step = MAX_JUMP;
            end
            if (dim >= dims) dim = dims - 1;
            nxt[dim] = fix_position(plus ? cur[dim] + step : cur[dim] - step,
                                    len, cfg_bound, dead);
            if (dead) nxt[dim] = cur[dim];
         end
      end
      lin = 0;
      for (int d = 0; d < dims; d++) lin = lin * len + nxt[d];
      res.new_coord_0 = nxt[0][9:0];
      res.new_coord_1 = (dims > 1) ? nxt[1][9:0] : '0;
      res.new_coord_2 = (dims > 2) ? nxt[2][9:0] : '0;
      res.new_coord_3 = (dims > 3) ? nxt[3][9:0] : '0;
      res.linear_patch = lin[PATCH_W-1:0];
      res.killed = dead;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at result %0d: %s got %0h expected %0h",
               result_count, what, got, want);
      mismatch_count++;
   endtask

   // Every strobed result is compared with the oldest pending prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (moves_pending.size() == 0) begin
            report_mismatch("unexpected result", rsp_payload.linear_patch, 0);
         end else begin
            want = moves_pending.pop_front();
            if (rsp_payload.new_coord_0 !== want.new_coord_0)
               report_mismatch("new_coord_0", rsp_payload.new_coord_0, want.new_coord_0);
            if (rsp_payload.new_coord_1 !== want.new_coord_1)
               report_mismatch("new_coord_1", rsp_payload.new_coord_1, want.new_coord_1);
            if (rsp_payload.new_coord_2 !== want.new_coord_2)
               report_mismatch("new_coord_2", rsp_payload.new_coord_2, want.new_coord_2);
            if (rsp_payload.new_coord_3 !== want.new_coord_3)
               report_mismatch("new_coord_3", rsp_payload.new_coord_3, want.new_coord_3);
            if (rsp_payload.linear_patch !== want.linear_patch)
               report_mismatch("linear_patch", rsp_payload.linear_patch, want.linear_patch);
            if (rsp_payload.moved !== want.moved)
               report_mismatch("moved", rsp_payload.moved, want.moved);
            if (rsp_payload.killed !== want.killed)
               report_mismatch("killed", rsp_payload.killed, want.killed);
         end
         result_count++;
      end
   end

   // Sends one request. The start line stays high across back-to-back requests,
   // so it is lowered only when an idle cycle is chosen or the caller finishes.
   task automatic send_request(req_type rq);
      while (($urandom_range(99) < idle_pct)) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      moves_pending = {moves_pending, predict_move(rq)};
      request_count++;
   endtask

   // Waits until every prediction has been matched, then lets the pipeline drain.
   task automatic wait_drained();
      start <= 1'b0;
      while (moves_pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle. The block must be idle.
   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         CSR_GRID_LENGTH:     cfg_length = value[10:0];
         CSR_DIMENSION_COUNT: cfg_dims = value[2:0];
         CSR_DISPERSAL_MODE:  cfg_disp = value[1:0];
         default:             cfg_bound = value[1:0];
      endcase
   endtask

   task automatic configure(int len, int dims, int disp, int bound);
      wait_drained();
      write_csr(CSR_GRID_LENGTH, len);
      write_csr(CSR_DIMENSION_COUNT, dims);
      write_csr(CSR_DISPERSAL_MODE, disp);
      write_csr(CSR_BOUNDARY_MODE, bound);
   endtask

   // Mostly coordinates inside the grid and jumps near its size, so that the
   // boundary rules are hit often; now and then anything the fields allow.
   function automatic req_type random_request();
      req_type     rq;
      int          len;
      len = (cfg_length < 2) ? 2 : ((cfg_length > MAX_LENGTH) ? MAX_LENGTH : int'(cfg_length));
      rq = req_type'($bits(req_type)'({$urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom}));
      if ($urandom_range(9) != 0) begin
         rq.coord_0 = COORD_W'($urandom_range(len - 1));
         rq.coord_1 = COORD_W'($urandom_range(len - 1));
         rq.coord_2 = COORD_W'($urandom_range(len - 1));
         rq.coord_3 = COORD_W'($urandom_range(len - 1));
         if ($urandom_range(3) != 0) rq.jump_distance = COORD_W'($urandom_range(1, 2 * len));
         if ($urandom_range(3) != 0) rq.disperse_prob = 17'($urandom_range(65536));
      end
      return rq;
   endfunction

   function automatic req_type mover(int c, logic [15:0] dir, int jump);
      req_type rq;
      rq = '0;
      rq.coord_0 = COORD_W'(c); rq.coord_1 = COORD_W'(c);
      rq.coord_2 = COORD_W'(c); rq.coord_3 = COORD_W'(c);
      rq.disperse_prob = 17'h10000;
      rq.direction_draw = dir;
      rq.jump_distance = COORD_W'(jump);
      rq.global_draw_0 = 16'hFFFF; rq.global_draw_3 = 16'h8000;
      return rq;
   endfunction

   // Edges of the grid with every mode and rule, plus the odd register values.
   task automatic test_directed();
      req_type rq;
      configure(16, 1, DISP_NEIGHBOR, BOUND_REFLECT);
      send_request(mover(0, 16'hFFFF, 1));
      send_request(mover(15, 16'h0000, 1));
      configure(1024, 4, DISP_DISTANCE, BOUND_CIRCULAR);
      send_request(mover(1023, 16'h1000, 1023));
      send_request(mover(0, 16'hF000, 0));
      configure(1024, 4, DISP_DISTANCE, BOUND_ABSORB);
      send_request(mover(1000, 16'h0000, 1023));
      send_request(mover(5, 16'hFFFF, 1023));
      configure(1024, 4, DISP_GLOBAL, BOUND_REFLECT);
      send_request(mover(7, 16'h0, 1));
      rq = mover(7, 16'h0, 1);
      rq.disperse_draw = 16'hFFFF;
      rq.disperse_prob = 17'h0FFFF;
      send_request(rq);
      rq.disperse_prob = 17'h1FFFF;
      send_request(rq);
      configure(2047, 7, 3, 3);
      send_request(mover(1023, 16'h8000, 1023));
      configure(1, 0, DISP_NEIGHBOR, BOUND_REFLECT);
      send_request(mover(1023, 16'h8000, 1));
      configure(0, 2, DISP_DISTANCE, BOUND_REFLECT);
      send_request(mover(3, 16'h8000, 5));
      configure(2, 2, DISP_DISTANCE, 3);
      send_request(mover(1023, 16'h4000, 1023));
      send_request(mover(1, 16'h0000, 7));
   endtask

   // Random requests under a range of settings, with sender idling and one
   // stretch with no idling at all.
   task automatic test_random();
      int lens[6];
      lens = '{2, 3, 16, 100, 1023, 1024};
      for (int phase = 0; phase < 20; phase++) begin
         configure(($urandom_range(9) == 0) ? $urandom_range(2047) : lens[$urandom_range(5)],
                   $urandom_range(7), $urandom_range(3), $urandom_range(3));
         idle_pct = (phase == 7) ? 0 : 16;
         for (int n = 0; n < 100; n++) begin
            send_request(random_request());
            // Hold off now and then until the pipeline is empty.
            if (n == 50 && phase % 5 == 0) begin
               start <= 1'b0;
               while (moves_pending.size() != 0) @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cfg_length = 11'd16;
      cfg_dims = 3'd1;
      cfg_disp = DISP_NEIGHBOR;
      cfg_bound = BOUND_REFLECT;
      request_count = 0;
      idle_pct = 16;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // The first request runs on the reset values of the registers.
      send_request(mover(15, 16'h0000, 1));
      test_directed();
      test_random();
      wait_drained();
      $display("%0d requests and %0d results over all modes, rules and grid sizes",
               request_count, result_count);
      if (mismatch_count == 0 && moves_pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
